/* sv/pmd_pkg.sv */
package pmd_pkg;

    // Field widths fixed by the interface.
    localparam int ANGLE_W   = 16;
    localparam int ERR_W     = 17;
    localparam int DIFF_W    = 18;
    localparam int SUM_W     = 32;
    localparam int GAIN_W    = 24;
    localparam int DUTY_W    = 16;
    localparam int BAND_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    // Product and accumulator widths. The unsigned gains are zero-extended
    // by one bit so that every product is a signed multiply.
    localparam int PROP_W = GAIN_W + 1 + ERR_W;
    localparam int INTG_W = GAIN_W + 1 + SUM_W;
    localparam int DERV_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W  = INTG_W + 1;
    localparam int FRAC_W = 16;
    localparam int MAG_W  = ACC_W - FRAC_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd5;

    // Reset values of the configuration registers.
    localparam logic signed [ANGLE_W-1:0] TARGET_ANGLE_RST = 16'sd960;
    localparam logic [GAIN_W-1:0]         PROP_GAIN_RST    = 24'd294912;
    localparam logic [GAIN_W-1:0]         INTEG_GAIN_RST   = 24'd328;
    localparam logic [GAIN_W-1:0]         DERIV_GAIN_RST   = 24'd0;
    localparam logic [DUTY_W-1:0]         DUTY_LIMIT_RST   = 16'd80;
    localparam logic [BAND_W-1:0]         DEAD_BAND_RST    = 15'd48;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

/* sv/pid_motor_drive_with_deadband.sv */
// An accepted angle word is registered in stage one, then in the output register.
// Throughput: one word per cycle while the m_ side keeps up; the 25x32 integral-gain
// multiply and the sum of the three products in the second stage set the cycle time.
// Reset (aresetn low, synchronous): both pipeline stages empty, error sum, last
// error and held direction cleared, configuration registers at their defaults.
module pid_motor_drive_with_deadband (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pmd_pkg::ANGLE_W-1:0]   s_measured_angle,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pmd_pkg::DUTY_W-1:0]           m_duty,
    output logic                                 m_drive_dir,
    output logic signed [pmd_pkg::ERR_W-1:0]     m_angle_error,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pmd_pkg::CFG_DAT_W-1:0]        cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; an index past the
    // last register is dropped. Unused high data bits are ignored.
    // ------------------------------------------------------------------
    logic signed [pmd_pkg::ANGLE_W-1:0] target_angle_reg;
    logic [pmd_pkg::GAIN_W-1:0]         prop_gain_reg;
    logic [pmd_pkg::GAIN_W-1:0]         integ_gain_reg;
    logic [pmd_pkg::GAIN_W-1:0]         deriv_gain_reg;
    logic [pmd_pkg::DUTY_W-1:0]         duty_limit_reg;
    logic [pmd_pkg::BAND_W-1:0]         dead_band_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_angle_reg <= pmd_pkg::TARGET_ANGLE_RST;
            prop_gain_reg    <= pmd_pkg::PROP_GAIN_RST;
            integ_gain_reg   <= pmd_pkg::INTEG_GAIN_RST;
            deriv_gain_reg   <= pmd_pkg::DERIV_GAIN_RST;
            duty_limit_reg   <= pmd_pkg::DUTY_LIMIT_RST;
            dead_band_reg    <= pmd_pkg::DEAD_BAND_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                pmd_pkg::REG_TARGET_ANGLE: begin
                    target_angle_reg <= cfg_data[pmd_pkg::ANGLE_W-1:0];
                end
                pmd_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_data[pmd_pkg::GAIN_W-1:0];
                pmd_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_data[pmd_pkg::GAIN_W-1:0];
                pmd_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_data[pmd_pkg::GAIN_W-1:0];
                pmd_pkg::REG_DUTY_LIMIT: duty_limit_reg <= cfg_data[pmd_pkg::DUTY_W-1:0];
                pmd_pkg::REG_DEAD_BAND:  dead_band_reg  <= cfg_data[pmd_pkg::BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. Stage one holds the error terms of the newest accepted
    // word; the output register holds a finished word. Stage one moves
    // forward whenever the output register is empty or being drained, so
    // a new word can enter every cycle while the m_ side keeps up.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_free;
    logic s_accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage one: error, saturating sum, error change and direction.
    // The controller state registers double as the stage-one operands:
    // after an accept, error_sum_reg, last_error_reg and dir_bit_reg hold
    // exactly the values that belong to the word now in stage one, and
    // they only change when that word leaves on the same edge.
    // ------------------------------------------------------------------
    logic signed [pmd_pkg::SUM_W-1:0]   error_sum_reg;
    logic signed [pmd_pkg::ERR_W-1:0]   last_error_reg;
    logic                               dir_bit_reg;
    logic signed [pmd_pkg::DIFF_W-1:0]  diff_reg;

    logic signed [pmd_pkg::ERR_W-1:0]   err_next;
    logic signed [pmd_pkg::SUM_W:0]     sum_wide;
    logic signed [pmd_pkg::SUM_W-1:0]   error_sum_next;
    logic signed [pmd_pkg::DIFF_W-1:0]  diff_next;
    logic                               dir_bit_next;

    always_comb begin
        err_next = {target_angle_reg[pmd_pkg::ANGLE_W-1], target_angle_reg}
                 - {s_measured_angle[pmd_pkg::ANGLE_W-1], s_measured_angle};

        sum_wide = {error_sum_reg[pmd_pkg::SUM_W-1], error_sum_reg}
                 + {{(pmd_pkg::SUM_W + 1 - pmd_pkg::ERR_W){err_next[pmd_pkg::ERR_W-1]}},
                    err_next};

        // The two top bits disagree only when the sum has left the 32-bit range.
        if (sum_wide[pmd_pkg::SUM_W] != sum_wide[pmd_pkg::SUM_W-1]) begin
            error_sum_next = sum_wide[pmd_pkg::SUM_W] ? pmd_pkg::SUM_MIN : pmd_pkg::SUM_MAX;
        end else begin
            error_sum_next = sum_wide[pmd_pkg::SUM_W-1:0];
        end

        diff_next = {err_next[pmd_pkg::ERR_W-1], err_next}
                  - {last_error_reg[pmd_pkg::ERR_W-1], last_error_reg};

        // Positive error drives forward, negative drives back, zero holds.
        if (err_next[pmd_pkg::ERR_W-1]) begin
            dir_bit_next = 1'b0;
        end else if (err_next != '0) begin
            dir_bit_next = 1'b1;
        end else begin
            dir_bit_next = dir_bit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            dir_bit_reg    <= 1'b0;
        end else if (s_accept) begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= err_next;
            dir_bit_reg    <= dir_bit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            diff_reg <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage two: three signed products against the zero-extended Q8.16
    // gains, their exact sum, then the magnitude with the 16 fraction bits
    // dropped. Dropping the fraction of the magnitude is the same as
    // truncating the signed value toward zero.
    // ------------------------------------------------------------------
    logic signed [pmd_pkg::PROP_W-1:0] prop_prod;
    logic signed [pmd_pkg::INTG_W-1:0] integ_prod;
    logic signed [pmd_pkg::DERV_W-1:0] deriv_prod;
    logic signed [pmd_pkg::ACC_W-1:0]  acc;
    logic [pmd_pkg::ACC_W-1:0]         acc_abs;
    logic [pmd_pkg::MAG_W-1:0]         mag;
    logic [pmd_pkg::ERR_W-1:0]         err_abs;
    logic [pmd_pkg::DUTY_W-1:0]        duty_next;

    assign prop_prod  = $signed({1'b0, prop_gain_reg})  * last_error_reg;
    assign integ_prod = $signed({1'b0, integ_gain_reg}) * error_sum_reg;
    assign deriv_prod = $signed({1'b0, deriv_gain_reg}) * diff_reg;

    always_comb begin
        acc = {{(pmd_pkg::ACC_W - pmd_pkg::PROP_W){prop_prod[pmd_pkg::PROP_W-1]}}, prop_prod}
            + {{(pmd_pkg::ACC_W - pmd_pkg::INTG_W){integ_prod[pmd_pkg::INTG_W-1]}}, integ_prod}
            + {{(pmd_pkg::ACC_W - pmd_pkg::DERV_W){deriv_prod[pmd_pkg::DERV_W-1]}}, deriv_prod};

        acc_abs = acc[pmd_pkg::ACC_W-1] ? (~acc + 1'b1) : acc;
        mag     = acc_abs[pmd_pkg::ACC_W-1:pmd_pkg::FRAC_W];

        err_abs = last_error_reg[pmd_pkg::ERR_W-1] ? (~last_error_reg + 1'b1) : last_error_reg;

        // Clamp first, then the deadband forces zero.
        if (mag > {{(pmd_pkg::MAG_W - pmd_pkg::DUTY_W){1'b0}}, duty_limit_reg}) begin
            duty_next = duty_limit_reg;
        end else begin
            duty_next = mag[pmd_pkg::DUTY_W-1:0];
        end
        if (err_abs < {{(pmd_pkg::ERR_W - pmd_pkg::BAND_W){1'b0}}, dead_band_reg}) begin
            duty_next = '0;
        end
    end

    // Output register.
    logic [pmd_pkg::DUTY_W-1:0]       duty_reg;
    logic                             drive_dir_reg;
    logic signed [pmd_pkg::ERR_W-1:0] angle_error_reg;

    always_ff @(posedge aclk) begin
        if (out_free && s1_valid_reg) begin
            duty_reg        <= duty_next;
            drive_dir_reg   <= dir_bit_reg;
            angle_error_reg <= last_error_reg;
        end
    end

    assign m_duty        = duty_reg;
    assign m_drive_dir   = drive_dir_reg;
    assign m_angle_error = angle_error_reg;

endmodule
